// File: src/hik_lookup_table_model_macros.svh
`ifndef HIK_LOOKUP_TABLE_MODEL_MACROS_SVH
`define HIK_LOOKUP_TABLE_MODEL_MACROS_SVH

// same-cycle check, sampled on i_clk and quiet while i_rst_n is low
`define HIK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check
`define HIK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/hiklut_pkg.sv
`timescale 1ns / 1ps

package hiklut_pkg;

    localparam int MAX_DIMS_DEF = 64;
    localparam int MAX_BINS_DEF = 32;

    localparam int ENTRY_W    = 40;
    localparam int ACC_W      = 48;
    localparam int FEAT_W     = 16;
    localparam int MULT_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;

    localparam logic [5:0]         BINS_RESET = 6'd32;
    localparam logic signed [36:0] BIAS_GAIN  = 37'sd20;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_ACC,
        ST_UP_MUL,
        ST_UP_RUN,
        ST_FINISH
    } t_state;

    function automatic logic signed [ENTRY_W-1:0] sat_entry(input logic signed [ENTRY_W:0] v);
        logic signed [ENTRY_W-1:0] res;
        if (v[ENTRY_W] != v[ENTRY_W-1]) begin
            res = v[ENTRY_W] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
        end else begin
            res = v[ENTRY_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] res;
        if (v[ACC_W] != v[ACC_W-1]) begin
            res = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = v[ACC_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: src/hiklut_ram.sv
`timescale 1ns / 1ps

module hiklut_ram #(
    parameter int DEPTH = 2112,
    parameter int AW    = 12,
    parameter int DW    = 40
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: src/hiklut_rmul.sv
`timescale 1ns / 1ps

module hiklut_rmul (
    input  logic                                 i_clk,
    input  logic signed [hiklut_pkg::ENTRY_W-1:0] i_a,
    input  logic [hiklut_pkg::FEAT_W-1:0]         i_b,
    output logic signed [hiklut_pkg::ENTRY_W:0]   o_q
);

    localparam int PW = hiklut_pkg::ENTRY_W + hiklut_pkg::FEAT_W + 1;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;

    assign prod = PW'(i_a) * $signed({1'b0, i_b});
    // add half an lsb, then floor by dropping the fraction bits
    assign rnd  = prod + PW'(hiklut_pkg::ROUND_HALF);

    always_ff @(posedge i_clk) begin
        o_q <= rnd[hiklut_pkg::FRAC_W +: hiklut_pkg::ENTRY_W + 1];
    end

endmodule

// File: src/hik_lookup_table_model.sv
`timescale 1ns / 1ps
`include "hik_lookup_table_model_macros.svh"

// Histogram intersection kernel lookup tables with a model bias.
// Input: one feature element per transaction, accepted at a clock edge with
// start high and busy low. Fields i_func, i_dim_index, i_bin, i_feature,
// i_mult, i_last. Config: i_cfg_we / i_cfg_wdata write bins_in_use at any edge.
// Output: on an element with i_last set, o_result_valid strobes for exactly
// one cycle carrying o_score and o_bias_out; the receiver cannot stall it.
// Sequencing (one item in flight, lower and upper tables in two simple dual-port
// RAMs with registered reads):
//   score element: states SC_RD, SC_MUL, SC_ACC, FINISH; the result strobe
//     is registered from FINISH
//   update element: one read-modify-write per bin over bins 0..nb, where
//     nb = min(bins_in_use, MAX_BINS), then FINISH
//   dimension out of range: straight to FINISH
// After reset the tables are swept to zero one entry a cycle, busy held high
// over all MAX_DIMS*(MAX_BINS+1) entries (2112 by default); config writes are
// taken during the sweep. Bias, accumulator and bins_in_use (32) reset at once.
module hik_lookup_table_model #(
    parameter int MAX_DIMS = hiklut_pkg::MAX_DIMS_DEF,
    parameter int MAX_BINS = hiklut_pkg::MAX_BINS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [5:0]         i_dim_index,
    input  logic [5:0]         i_bin,
    input  logic [15:0]        i_feature,
    input  logic signed [31:0] i_mult,
    input  logic               i_last,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_wdata,
    output logic               o_result_valid,
    output logic signed [47:0] o_score,
    output logic signed [47:0] o_bias_out
);

    localparam int ROW_LEN = MAX_BINS + 1;
    localparam int DEPTH   = MAX_DIMS * ROW_LEN;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW      = $clog2(ROW_LEN);
    localparam int CW      = (BW > 6) ? BW : 6;
    localparam int EW      = hiklut_pkg::ENTRY_W;
    localparam int XW      = hiklut_pkg::ACC_W;

    hiklut_pkg::t_state r_state, n_state;

    logic [5:0]              r_cfg_bins;
    logic [AW-1:0]           r_clr;
    logic                    r_func;
    logic                    r_last;
    logic [BW-1:0]           r_bin;
    logic [BW-1:0]           r_nb;
    logic [BW-1:0]           r_j;
    logic [AW-1:0]           r_base;
    logic [15:0]             r_feature;
    logic signed [31:0]      r_mult;
    logic signed [EW-1:0]    r_up_hold;
    logic signed [XW-1:0]    r_accum;
    logic signed [XW-1:0]    r_bias;
    logic                    r_out_valid;
    logic signed [XW-1:0]    r_score;
    logic signed [XW-1:0]    r_bias_out;

    logic                    accept;
    logic [CW-1:0]           cfg_ext;
    logic [CW-1:0]           nb_c;
    logic [CW-1:0]           bin_c;
    logic                    dim_ok;

    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic                    ram_we_lo;
    logic                    ram_we_up;
    logic [AW-1:0]           ram_waddr;
    logic [EW-1:0]           lo_wdata;
    logic [EW-1:0]           up_wdata;
    logic [EW-1:0]           lo_rdata;
    logic [EW-1:0]           up_rdata;

    logic signed [EW-1:0]    mul_a;
    logic signed [EW:0]      mul_q;

    logic signed [EW:0]      lo_sum;
    logic signed [EW:0]      up_sum;
    logic signed [EW+1:0]    term;
    logic signed [XW:0]      acc_sum;
    logic signed [36:0]      bias_inc;
    logic signed [XW:0]      bias_sum;
    logic signed [XW-1:0]    bias_new;

    assign accept  = start && (r_state == hiklut_pkg::ST_IDLE);
    assign busy    = (r_state != hiklut_pkg::ST_IDLE);

    // effective bin limit and clamped bin
    assign cfg_ext = CW'(r_cfg_bins);
    assign nb_c    = (cfg_ext > CW'(MAX_BINS)) ? CW'(MAX_BINS) : cfg_ext;
    assign bin_c   = (CW'(i_bin) > nb_c) ? nb_c : CW'(i_bin);
    assign dim_ok  = ({26'd0, i_dim_index} < 32'(MAX_DIMS));

    // read-modify-write arithmetic
    assign lo_sum   = (EW+1)'($signed(lo_rdata)) + (EW+1)'(r_mult);
    assign up_sum   = (EW+1)'($signed(up_rdata)) + mul_q;
    assign lo_wdata = (r_state == hiklut_pkg::ST_CLEAR) ? '0 : hiklut_pkg::sat_entry(lo_sum);
    assign up_wdata = (r_state == hiklut_pkg::ST_CLEAR) ? '0 : hiklut_pkg::sat_entry(up_sum);

    assign term     = (EW+2)'(mul_q) + (EW+2)'(r_up_hold);
    assign acc_sum  = (XW+1)'(r_accum) + (XW+1)'(term);

    assign bias_inc = 37'(r_mult) * hiklut_pkg::BIAS_GAIN;
    assign bias_sum = (XW+1)'(r_bias) + (XW+1)'(bias_inc);
    assign bias_new = hiklut_pkg::sat_acc(bias_sum);

    // update items multiply mult by feature, score items lower entry by feature
    assign mul_a = r_func ? EW'(r_mult) : $signed(lo_rdata);

    hiklut_rmul u_rmul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (r_feature),
        .o_q   (mul_q)
    );

    hiklut_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_lo),
        .i_waddr (ram_waddr),
        .i_wdata (lo_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (lo_rdata)
    );

    hiklut_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (EW)
    ) u_upper_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we_up),
        .i_waddr (ram_waddr),
        .i_wdata (up_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (up_rdata)
    );

    always_comb begin
        n_state   = r_state;
        ram_re    = 1'b0;
        ram_raddr = r_base;
        ram_we_lo = 1'b0;
        ram_we_up = 1'b0;
        ram_waddr = r_base + AW'(r_j);
        case (r_state)
            hiklut_pkg::ST_CLEAR: begin
                ram_we_lo = 1'b1;
                ram_we_up = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = hiklut_pkg::ST_IDLE;
                end
            end
            hiklut_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!dim_ok) begin
                        n_state = hiklut_pkg::ST_FINISH;
                    end else if (i_func) begin
                        n_state = hiklut_pkg::ST_UP_MUL;
                    end else begin
                        n_state = hiklut_pkg::ST_SC_RD;
                    end
                end
            end
            hiklut_pkg::ST_SC_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_base + AW'(r_bin);
                n_state   = hiklut_pkg::ST_SC_MUL;
            end
            hiklut_pkg::ST_SC_MUL: begin
                n_state = hiklut_pkg::ST_SC_ACC;
            end
            hiklut_pkg::ST_SC_ACC: begin
                n_state = hiklut_pkg::ST_FINISH;
            end
            hiklut_pkg::ST_UP_MUL: begin
                // fetch bin 0 while the update product settles
                ram_re    = 1'b1;
                ram_raddr = r_base;
                n_state   = hiklut_pkg::ST_UP_RUN;
            end
            hiklut_pkg::ST_UP_RUN: begin
                // write bin r_j back while bin r_j+1 is being read
                ram_we_lo = (r_j <= r_bin);
                ram_we_up = (r_j > r_bin);
                if (r_j != r_nb) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_base + AW'(r_j) + AW'(1);
                end else begin
                    n_state = hiklut_pkg::ST_FINISH;
                end
            end
            hiklut_pkg::ST_FINISH: begin
                n_state = hiklut_pkg::ST_IDLE;
            end
            default: begin
                n_state = hiklut_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hiklut_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_cfg_bins  <= hiklut_pkg::BINS_RESET;
            r_accum     <= '0;
            r_bias      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == hiklut_pkg::ST_FINISH) && r_last;
            if (i_cfg_we) begin
                r_cfg_bins <= i_cfg_wdata;
            end
            if (r_state == hiklut_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == hiklut_pkg::ST_SC_ACC) begin
                r_accum <= hiklut_pkg::sat_acc(acc_sum);
            end
            if ((r_state == hiklut_pkg::ST_FINISH) && r_last) begin
                r_accum <= '0;
                if (r_func) begin
                    r_bias <= bias_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= i_func;
            r_last    <= i_last;
            r_bin     <= BW'(bin_c);
            r_nb      <= BW'(nb_c);
            r_base    <= AW'(32'(i_dim_index) * ROW_LEN);
            r_feature <= i_feature;
            r_mult    <= i_mult;
        end
        if (r_state == hiklut_pkg::ST_UP_MUL) begin
            r_j <= '0;
        end else if (r_state == hiklut_pkg::ST_UP_RUN) begin
            r_j <= r_j + BW'(1);
        end
        if (r_state == hiklut_pkg::ST_SC_MUL) begin
            r_up_hold <= $signed(up_rdata);
        end
        if (r_state == hiklut_pkg::ST_FINISH) begin
            r_score    <= r_func ? '0 : r_accum;
            r_bias_out <= r_func ? bias_new : r_bias;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_score        = r_score;
    assign o_bias_out     = r_bias_out;

    `HIK_ASSERT_NEXT(a_result_follows_finish, (r_state == hiklut_pkg::ST_FINISH) && r_last, o_result_valid, "last element finished without a result strobe")
    `HIK_ASSERT_NEXT(a_strobe_one_cycle, o_result_valid, !o_result_valid, "result strobe held for more than one cycle")
    `HIK_ASSERT_NOW(a_update_index_bound, r_state == hiklut_pkg::ST_UP_RUN, r_j <= r_nb, "update sweep ran past the bin limit")
    `HIK_ASSERT_NOW(a_update_score_zero, o_result_valid && r_func, o_score == '0, "update transaction reported a nonzero score")

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam bit FUNC_SCORE  = 1'b0;
    localparam bit FUNC_UPDATE = 1'b1;
    localparam int ROW_LEN       = hiklut_pkg::MAX_BINS_DEF + 1;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic               func;
        logic [5:0]         dim;
        logic [5:0]         bin;
        logic [15:0]        feature;
        logic signed [31:0] mult;
        logic               last;
    } t_element;

    typedef struct packed {
        logic signed [hiklut_pkg::ACC_W-1:0] score;
        logic signed [hiklut_pkg::ACC_W-1:0] bias;
    } t_kernel_result;

    typedef struct packed {
        t_element       elem;
        logic           typed;
        t_kernel_result want;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_func;
    logic [5:0]         i_dim_index;
    logic [5:0]         i_bin;
    logic [15:0]        i_feature;
    logic signed [31:0] i_mult;
    logic               i_last;
    logic               i_cfg_we;
    logic [5:0]         i_cfg_wdata;
    logic               o_result_valid;
    logic signed [47:0] o_score;
    logic signed [47:0] o_bias_out;

    // typed-in expectation travelling with the directed transaction
    logic           row_typed;
    t_kernel_result row_want;

    hik_lookup_table_model dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_dim_index    (i_dim_index),
        .i_bin          (i_bin),
        .i_feature      (i_feature),
        .i_mult         (i_mult),
        .i_last         (i_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_score        (o_score),
        .o_bias_out     (o_bias_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------
    // kernel table predictor
    // ---------------------------------------------------------------
    longint lower_tbl [hiklut_pkg::MAX_DIMS_DEF*ROW_LEN];
    longint upper_tbl [hiklut_pkg::MAX_DIMS_DEF*ROW_LEN];
    longint bias_model;
    longint accum_model;
    logic [5:0] bins_model;

    t_kernel_result kernel_results_due[$];

    int n_accepted, n_scored, n_updated, n_checked, n_errors, n_cfg_writes;

    function automatic longint clamp_bits(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Q.32 -> Q.16, half rounds upward
    function automatic longint q16_round(input longint p);
        return (p + hiklut_pkg::ROUND_HALF) >>> hiklut_pkg::FRAC_W;
    endfunction

    task automatic score_or_update(input t_element e, output bit got,
                                   output t_kernel_result res);
        int nb;
        int bi;
        int base;
        int j;
        longint fv;
        longint mv;
        longint upd;
        nb   = (int'(bins_model) > hiklut_pkg::MAX_BINS_DEF) ? hiklut_pkg::MAX_BINS_DEF
                                                              : int'(bins_model);
        bi   = (int'(e.bin) > nb) ? nb : int'(e.bin);
        base = int'(e.dim) * ROW_LEN;
        fv   = longint'(e.feature);
        mv   = longint'(e.mult);
        got  = 1'b0;
        res  = '0;
        if (e.func == FUNC_SCORE) begin
            accum_model = clamp_bits(accum_model + q16_round(lower_tbl[base+bi] * fv)
                                     + upper_tbl[base+bi], hiklut_pkg::ACC_W);
        end else begin
            upd = q16_round(mv * fv);
            for (j = 0; j <= bi; j++)
                lower_tbl[base+j] = clamp_bits(lower_tbl[base+j] + mv, hiklut_pkg::ENTRY_W);
            for (j = bi + 1; j <= nb; j++)
                upper_tbl[base+j] = clamp_bits(upper_tbl[base+j] + upd, hiklut_pkg::ENTRY_W);
        end
        if (e.last) begin
            if (e.func == FUNC_SCORE) begin
                res.score = accum_model[hiklut_pkg::ACC_W-1:0];
            end else begin
                bias_model = clamp_bits(bias_model + longint'(hiklut_pkg::BIAS_GAIN) * mv,
                                        hiklut_pkg::ACC_W);
            end
            res.bias    = bias_model[hiklut_pkg::ACC_W-1:0];
            accum_model = 0;
            got         = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_kernel_result want;
        t_kernel_result got_res;
        t_element       e;
        bit             got;
        if (!i_rst_n) begin
            foreach (lower_tbl[k]) begin
                lower_tbl[k] = 0;
                upper_tbl[k] = 0;
            end
            bias_model  = 0;
            accum_model = 0;
            bins_model  = hiklut_pkg::BINS_RESET;
        end else begin
            if (o_result_valid) begin
                if (kernel_results_due.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected result, score %0d bias %0d",
                             $time, o_score, o_bias_out);
                end else begin
                    want = kernel_results_due.pop_front();
                    n_checked++;
                    if (o_score !== want.score) begin
                        n_errors++;
                        $display("%0t: score mismatch, expected %0d, got %0d",
                                 $time, want.score, o_score);
                    end
                    if (o_bias_out !== want.bias) begin
                        n_errors++;
                        $display("%0t: bias mismatch, expected %0d, got %0d",
                                 $time, want.bias, o_bias_out);
                    end
                end
            end
            if (i_cfg_we) begin
                bins_model = i_cfg_wdata;
                n_cfg_writes++;
            end
            if (start && !busy) begin
                e = '{i_func, i_dim_index, i_bin, i_feature, i_mult, i_last};
                score_or_update(e, got, got_res);
                n_accepted++;
                if (e.func == FUNC_SCORE) n_scored++;
                else n_updated++;
                if (got) begin
                    kernel_results_due.push_back(row_typed ? row_want : got_res);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------
    int burst_left;
    int drive_nb;
    bit sender_active;
    int hot_dims[4] = '{0, 1, 2, 63};

    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(30, 80);
        else burst_left = $urandom_range(0, 10);
        return $urandom_range(1, 40);
    endfunction

    task automatic send_element(input t_element e, input logic typed,
                                input t_kernel_result want, input int gap_after);
        start       <= 1'b1;
        i_func      <= e.func;
        i_dim_index <= e.dim;
        i_bin       <= e.bin;
        i_feature   <= e.feature;
        i_mult      <= e.mult;
        i_last      <= e.last;
        row_typed   <= typed;
        row_want    <= want;
        sender_active = 1'b1;
        do @(posedge i_clk); while (busy);
        if (gap_after > 0) begin
            start <= 1'b0;
            sender_active = 1'b0;
            repeat (gap_after) @(posedge i_clk);
        end
    endtask

    // hold the sender off until every pending result has come back
    task automatic wait_for_results();
        int guard;
        if (sender_active) begin
            start <= 1'b0;
            sender_active = 1'b0;
        end
        guard = 0;
        do begin
            @(posedge i_clk);
            guard++;
        end while (kernel_results_due.size() != 0 && guard < 20000);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bins(input logic [5:0] v);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        drive_nb = (int'(v) > hiklut_pkg::MAX_BINS_DEF) ? hiklut_pkg::MAX_BINS_DEF : int'(v);
    endtask

    function automatic t_element rand_element(input bit fn, input bit lst);
        t_element e;
        e.func = fn;
        e.dim  = ($urandom_range(0, 9) < 6) ? 6'(hot_dims[$urandom_range(0, 3)])
                                             : 6'($urandom_range(0, 63));
        e.bin  = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(0, drive_nb + 1))
                                             : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 6))
            0:       e.feature = 16'h0000;
            1:       e.feature = 16'hFFFF;
            default: e.feature = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       e.mult = 32'sh7FFF_FFFF;
            1:       e.mult = 32'sh8000_0000;
            2, 3, 4: e.mult = $urandom_range(0, 262144) - 131072;
            default: e.mult = $urandom;
        endcase
        e.last = lst;
        return e;
    endfunction

    // feature vectors: mostly one func per vector, some mixed or unterminated
    task automatic run_random_phase(input int n);
        int made;
        int len;
        int kind;
        int k;
        bit fn;
        bit lst;
        made = 0;
        while (made < n) begin
            len  = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            kind = $urandom_range(0, 9);
            for (k = 0; k < len; k++) begin
                if (kind < 5) fn = FUNC_SCORE;
                else if (kind < 8) fn = FUNC_UPDATE;
                else fn = $urandom_range(0, 1);
                lst = (k == len - 1) && ($urandom_range(0, 19) != 0);
                send_element(rand_element(fn, lst), 1'b0, '0, next_gap());
                made++;
            end
            if ($urandom_range(0, 24) == 0) wait_for_results();
        end
    endtask

    // push one table row to its positive or negative limit
    task automatic pump_row(input int d, input logic signed [31:0] m, input int count);
        t_element e;
        int i;
        for (i = 0; i < count; i++) begin
            e = '{FUNC_UPDATE, d[5:0], 6'd0, 16'hFFFF, m, $urandom_range(0, 9) == 0};
            send_element(e, 1'b0, '0, next_gap());
        end
    endtask

    task automatic score_saturated_rows(input int len);
        t_element e;
        int i;
        for (i = 0; i < len; i++) begin
            e = '{FUNC_SCORE, ($urandom_range(0, 1) ? 6'd63 : 6'd62),
                  6'($urandom_range(0, 2)), 16'($urandom_range(32768, 65535)),
                  32'sd0, i == len - 1};
            send_element(e, 1'b0, '0, next_gap());
        end
    endtask

    function automatic t_directed_row drow(input bit fn, input int d, input int b,
                                           input int f, input logic signed [31:0] m,
                                           input bit lst, input bit typed,
                                           input longint ws, input longint wb);
        t_directed_row r;
        r.elem       = '{fn, d[5:0], b[5:0], f[15:0], m, lst};
        r.typed      = typed;
        r.want.score = ws[hiklut_pkg::ACC_W-1:0];
        r.want.bias  = wb[hiklut_pkg::ACC_W-1:0];
        return r;
    endfunction

    t_directed_row directed_rows[$];
    logic [5:0]    bins_plan[$];

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_SCORE;
        i_dim_index <= '0;
        i_bin       <= '0;
        i_feature   <= '0;
        i_mult      <= '0;
        i_last      <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        row_typed   <= 1'b0;
        row_want    <= '0;
        burst_left    = 0;
        sender_active = 1'b0;
        drive_nb      = hiklut_pkg::MAX_BINS_DEF;

        // empty tables after reset
        directed_rows.push_back(drow(FUNC_SCORE, 0, 0, 'hFFFF, 0, 1, 1, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 63, 63, 0, 32'sh7FFF_FFFF, 1, 1, 0, 0));
        directed_rows.push_back(drow(FUNC_UPDATE, 5, 10, 'h8000, 32'sh0001_0000, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 5, 3, 'hFFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 5, 20, 1, 0, 1, 0, 0, 0));
        // bias extremes: +20*max, then back down by 20*min
        directed_rows.push_back(drow(FUNC_UPDATE, 63, 63, 'hFFFF, 32'sh7FFF_FFFF, 1, 1,
                                     0, 64'sd42949672940));
        directed_rows.push_back(drow(FUNC_UPDATE, 63, 0, 'hFFFF, 32'sh8000_0000, 1, 1,
                                     0, -20));
        directed_rows.push_back(drow(FUNC_SCORE, 63, 32, 'hFFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 63, 0, 'hFFFF, 0, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 63, 40, 'h8000, 0, 1, 0, 0, 0));
        // exact halves round upward on both signs
        directed_rows.push_back(drow(FUNC_UPDATE, 1, 0, 'h8000, 3, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_UPDATE, 2, 0, 'h8000, -3, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 1, 5, 'h8000, 0, 0, 0, 0, 0));
        // update closing a score vector reports zero score
        directed_rows.push_back(drow(FUNC_UPDATE, 1, 31, 'h1234, -1, 1, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 2, 1, 'hFFFF, 0, 1, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_UPDATE, 3, 0, 0, 0, 1, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_UPDATE, 0, 32, 'hFFFF, 1, 0, 0, 0, 0));
        directed_rows.push_back(drow(FUNC_SCORE, 0, 32, 'hFFFF, 0, 1, 0, 0, 0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_element(directed_rows[r].elem, directed_rows[r].typed,
                         directed_rows[r].want, next_gap());
        end

        bins_plan = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd7, 6'd33,
                      6'($urandom_range(2, 31)), 6'd32};
        foreach (bins_plan[p]) begin
            set_bins(bins_plan[p]);
            run_random_phase(25);
        end

        // drive a row of each sign into table saturation, then score it
        set_bins(6'd1);
        pump_row(63, 32'sh7FFF_FFFF, 270);
        pump_row(62, 32'sh8000_0000, 270);
        score_saturated_rows(16);
        score_saturated_rows(24);
        set_bins(6'd32);
        run_random_phase(20);

        wait_for_results();
        if (kernel_results_due.size() != 0) begin
            n_errors += kernel_results_due.size();
            $display("%0t: %0d expected results never arrived",
                     $time, kernel_results_due.size());
        end
        $display("covered %0d transactions (%0d score, %0d update), %0d results checked",
                 n_accepted, n_scored, n_updated, n_checked);
        $display("bins_in_use written %0d times incl. 0, 1, 32, 33 and 63; %0d mismatches",
                 n_cfg_writes, n_errors);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
